// ===== hdl/msaq_pkg.sv =====
// ----------------------------------------------------------------------------
// msaq_pkg
// shared widths, opcodes, status codes and register map of the sdu queue
// ----------------------------------------------------------------------------
package msaq_pkg;

    localparam int SIZE_W   = 13;   // sdu size and read offset
    localparam int CFG_W    = 13;   // max pdu byte register
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 6;
    localparam int PDU_W    = 13;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [CFG_W-1:0]   MAX_PDU_RESET = 13'd4096;
    localparam logic [PADDR_W-1:0] ADDR_MAX_PDU  = 2'd0;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_BYTE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_BUSY      = 3'd3,
        ST_END       = 3'd4
    } t_status;

endpackage

// ===== hdl/mac_sdu_aggregation_queue.sv =====
// ----------------------------------------------------------------------------
// mac_sdu_aggregation_queue
// collects sdus into a mac pdu payload, control sdus ahead of data sdus
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  ---------------------------------
// command   in         start high, busy low      i_opcode i_sdu_size i_is_data
//                                                i_sdu_byte
// result    out        o_done, one cycle pulse   o_status o_read_byte
//                                                o_read_is_data o_last_of_sdu
//                                                o_pdu_bytes o_sdu_total
// config    in/out     apb, pready tied high     max_pdu_bytes at byte address 0
//
// timing: the result of an item appears the cycle after its last step.
//   sdu byte, clear and every rejected item end in S_IDLE, so these run back to back
//   begin: for each sdu queued behind the insert point the order table is moved up
//   one entry per cycle through its single write port (S_SHIFT), then S_INSERT writes
//   the new entry; read: table reads (S_RD_TAB) until an sdu with bytes left, then a
//   byte read (S_RD_DAT); running off the end instead returns ST_END from S_RD_TAB
// reset: synchronous, clears the counters and the read position and sets the
//   size limit to 4096; the memories are not swept, no clearing pass
// busy is high while an item is in progress; the receiver cannot stall
//
// payload bytes are stored append-only in arrival order (nothing leaves the
// queue before a clear), the order table holds size, flag and start address
// per queue position, so an insert only moves table entries, never bytes
// ----------------------------------------------------------------------------
module mac_sdu_aggregation_queue #(
    parameter int BUFFER_BYTES = 4096,
    parameter int MAX_SDUS     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command item
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_opcode,
    input  logic [msaq_pkg::SIZE_W-1:0]     i_sdu_size,
    input  logic                            i_is_data,
    input  logic [msaq_pkg::BYTE_W-1:0]     i_sdu_byte,
    // result item
    output logic                            o_done,
    output logic [msaq_pkg::STATUS_W-1:0]   o_status,
    output logic [msaq_pkg::BYTE_W-1:0]     o_read_byte,
    output logic                            o_read_is_data,
    output logic                            o_last_of_sdu,
    output logic [msaq_pkg::PDU_W-1:0]      o_pdu_bytes,
    output logic [msaq_pkg::TOTAL_W-1:0]    o_sdu_total,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msaq_pkg::PADDR_W-1:0]    paddr,
    input  logic [msaq_pkg::PDATA_W-1:0]    pwdata,
    output logic [msaq_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    import msaq_pkg::*;

    // widths that follow from the buffer and table sizes
    localparam int AW    = $clog2(BUFFER_BYTES);          // payload address
    localparam int LENW  = $clog2(BUFFER_BYTES + 1);      // payload length
    localparam int TW    = $clog2(MAX_SDUS);              // table index
    localparam int QW    = $clog2(MAX_SDUS + 1);          // sdu count
    localparam int SUMW  = ((LENW > SIZE_W) ? LENW : SIZE_W) + 1;
    localparam int CMPW  = SUMW + 2;                      // pdu size compare

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              flag;
        logic [AW-1:0]     start;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_INSERT,
        S_RD_TAB,
        S_RD_DAT
    } t_state;

    // state registers
    t_state              r_state, n_state;
    logic [QW-1:0]       r_queued, n_queued;
    logic [QW-1:0]       r_control, n_control;
    logic [LENW-1:0]     r_len, n_len;
    logic [SIZE_W-1:0]   r_open_rem, n_open_rem;
    logic [AW-1:0]       r_open_addr, n_open_addr;
    logic [QW-1:0]       r_rd_sdu, n_rd_sdu;
    logic [SIZE_W-1:0]   r_rd_off, n_rd_off;
    logic [CFG_W-1:0]    r_max, n_max;
    // pending insert
    logic [TW-1:0]       r_pos, n_pos;
    logic [TW-1:0]       r_wr_idx, n_wr_idx;
    logic [SIZE_W-1:0]   r_new_size, n_new_size;
    logic                r_new_flag, n_new_flag;
    // read in flight
    logic                r_lat_flag, n_lat_flag;
    logic                r_lat_last, n_lat_last;
    // result
    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [BYTE_W-1:0]   r_rbyte, n_rbyte;
    logic                r_rflag, n_rflag;
    logic                r_rlast, n_rlast;

    // memory ports
    logic                tab_we;
    logic [TW-1:0]       tab_waddr;
    t_entry              tab_wdata;
    logic [TW-1:0]       tab_raddr;
    logic [EW-1:0]       tab_rdata_raw;
    t_entry              tab_rdata;
    logic                pay_we;
    logic [AW-1:0]       pay_waddr;
    logic [BYTE_W-1:0]   pay_wdata;
    logic [AW-1:0]       pay_raddr;
    logic [BYTE_W-1:0]   pay_rdata;

    // admission arithmetic
    logic [CMPW-1:0]     w_pdu_now;
    logic [CMPW-1:0]     w_pdu_need;
    logic [SUMW-1:0]     w_len_need;
    logic                w_too_large;
    logic                w_full;
    logic [QW-1:0]       w_pos;
    logic [QW-1:0]       w_q_minus1;
    logic [QW-1:0]       w_rd_next;
    logic [SUMW-1:0]     w_rd_sum;
    logic [SIZE_W:0]     w_off_next;
    logic                w_cfg_wr;

    msaq_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SDUS)
    ) u_table_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tab_we),
        .i_wr_addr (tab_waddr),
        .i_wr_data (tab_wdata),
        .i_rd_addr (tab_raddr),
        .o_rd_data (tab_rdata_raw)
    );

    assign tab_rdata = t_entry'(tab_rdata_raw);

    msaq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pay_we),
        .i_wr_addr (pay_waddr),
        .i_wr_data (pay_wdata),
        .i_rd_addr (pay_raddr),
        .o_rd_data (pay_rdata)
    );

    // pdu size is 2 header bytes, 2 per sdu, plus the payload
    assign w_pdu_now   = CMPW'(2) + (CMPW'(r_queued) << 1) + CMPW'(r_len);
    assign w_pdu_need  = CMPW'(i_sdu_size) + CMPW'(2) + w_pdu_now;
    assign w_len_need  = SUMW'(r_len) + SUMW'(i_sdu_size);
    assign w_too_large = (w_pdu_need > CMPW'(r_max)) ||
                         (w_len_need > SUMW'(BUFFER_BYTES));
    assign w_full      = (r_queued >= QW'(MAX_SDUS));

    // control sdus go behind the last control sdu, data at the tail
    assign w_pos       = i_is_data ? r_queued : r_control;
    assign w_q_minus1  = r_queued - QW'(1);
    assign w_rd_next   = r_rd_sdu + QW'(1);
    assign w_rd_sum    = SUMW'(tab_rdata.start) + SUMW'(r_rd_off);
    assign w_off_next  = {1'b0, r_rd_off} + (SIZE_W+1)'(1);

    assign w_cfg_wr    = psel && penable && pwrite && (paddr == ADDR_MAX_PDU);

    always_comb begin
        n_state     = r_state;
        n_queued    = r_queued;
        n_control   = r_control;
        n_len       = r_len;
        n_open_rem  = r_open_rem;
        n_open_addr = r_open_addr;
        n_rd_sdu    = r_rd_sdu;
        n_rd_off    = r_rd_off;
        n_max       = r_max;
        n_pos       = r_pos;
        n_wr_idx    = r_wr_idx;
        n_new_size  = r_new_size;
        n_new_flag  = r_new_flag;
        n_lat_flag  = r_lat_flag;
        n_lat_last  = r_lat_last;
        n_done      = 1'b0;
        n_status    = r_status;
        n_rbyte     = '0;
        n_rflag     = 1'b0;
        n_rlast     = 1'b0;

        tab_we          = 1'b0;
        tab_waddr       = r_wr_idx;
        tab_wdata       = tab_rdata;
        tab_raddr       = r_rd_sdu[TW-1:0];
        pay_we          = 1'b0;
        pay_waddr       = r_open_addr;
        pay_wdata       = i_sdu_byte;
        pay_raddr       = w_rd_sum[AW-1:0];

        if (w_cfg_wr) begin
            n_max = pwdata[CFG_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_opcode'(i_opcode))
                        OP_BEGIN: begin
                            if (r_open_rem != '0) begin
                                n_done   = 1'b1;
                                n_status = ST_BUSY;
                            end else if (w_too_large) begin
                                n_done   = 1'b1;
                                n_status = ST_TOO_LARGE;
                            end else if (w_full) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_pos      = w_pos[TW-1:0];
                                n_new_size = i_sdu_size;
                                n_new_flag = i_is_data;
                                if (w_pos == r_queued) begin
                                    n_state = S_INSERT;
                                end else begin
                                    // start moving the tail up, top entry first
                                    tab_raddr = w_q_minus1[TW-1:0];
                                    n_wr_idx  = r_queued[TW-1:0];
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        OP_BYTE: begin
                            n_done = 1'b1;
                            if (r_open_rem == '0) begin
                                n_status = ST_BUSY;
                            end else begin
                                pay_we      = 1'b1;
                                n_open_addr = r_open_addr + AW'(1);
                                n_open_rem  = r_open_rem - SIZE_W'(1);
                                n_status    = ST_OK;
                            end
                        end
                        OP_READ: begin
                            if (r_open_rem != '0) begin
                                n_done   = 1'b1;
                                n_status = ST_BUSY;
                            end else if (r_rd_sdu >= r_queued) begin
                                n_done   = 1'b1;
                                n_status = ST_END;
                            end else begin
                                tab_raddr = r_rd_sdu[TW-1:0];
                                n_state   = S_RD_TAB;
                            end
                        end
                        OP_CLEAR: begin
                            n_queued    = '0;
                            n_control   = '0;
                            n_len       = '0;
                            n_open_rem  = '0;
                            n_open_addr = '0;
                            n_rd_sdu    = '0;
                            n_rd_off    = '0;
                            n_done      = 1'b1;
                            n_status    = ST_OK;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // entry below the write slot arrives this cycle
                tab_we    = 1'b1;
                tab_waddr = r_wr_idx;
                tab_wdata = tab_rdata;
                if ((r_wr_idx - TW'(1)) == r_pos) begin
                    n_state = S_INSERT;
                end else begin
                    tab_raddr = r_wr_idx - TW'(2);
                    n_wr_idx  = r_wr_idx - TW'(1);
                end
            end

            S_INSERT: begin
                tab_we          = 1'b1;
                tab_waddr       = r_pos;
                tab_wdata.size  = r_new_size;
                tab_wdata.flag  = r_new_flag;
                tab_wdata.start = r_len[AW-1:0];
                n_queued        = r_queued + QW'(1);
                if (!r_new_flag) begin
                    n_control = r_control + QW'(1);
                end
                n_len       = r_len + LENW'(r_new_size);
                n_open_rem  = r_new_size;
                n_open_addr = r_len[AW-1:0];
                n_done      = 1'b1;
                n_status    = ST_OK;
                n_state     = S_IDLE;
            end

            S_RD_TAB: begin
                if (r_rd_off >= tab_rdata.size) begin
                    // sdu used up or empty, move on
                    n_rd_sdu = w_rd_next;
                    n_rd_off = '0;
                    if (w_rd_next >= r_queued) begin
                        n_done   = 1'b1;
                        n_status = ST_END;
                        n_state  = S_IDLE;
                    end else begin
                        tab_raddr = w_rd_next[TW-1:0];
                    end
                end else begin
                    pay_raddr  = w_rd_sum[AW-1:0];
                    n_lat_flag = tab_rdata.flag;
                    if (w_off_next >= {1'b0, tab_rdata.size}) begin
                        n_lat_last = 1'b1;
                        n_rd_sdu   = w_rd_next;
                        n_rd_off   = '0;
                    end else begin
                        n_lat_last = 1'b0;
                        n_rd_off   = w_off_next[SIZE_W-1:0];
                    end
                    n_state = S_RD_DAT;
                end
            end

            S_RD_DAT: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_rbyte  = pay_rdata;
                n_rflag  = r_lat_flag;
                n_rlast  = r_lat_last;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_control   <= '0;
            r_len       <= '0;
            r_open_rem  <= '0;
            r_open_addr <= '0;
            r_rd_sdu    <= '0;
            r_rd_off    <= '0;
            r_max       <= MAX_PDU_RESET;
            r_done      <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_queued    <= n_queued;
            r_control   <= n_control;
            r_len       <= n_len;
            r_open_rem  <= n_open_rem;
            r_open_addr <= n_open_addr;
            r_rd_sdu    <= n_rd_sdu;
            r_rd_off    <= n_rd_off;
            r_max       <= n_max;
            r_done      <= n_done;
            r_status    <= n_status;
        end
        // payload of pending work and results, no reset needed
        r_pos      <= n_pos;
        r_wr_idx   <= n_wr_idx;
        r_new_size <= n_new_size;
        r_new_flag <= n_new_flag;
        r_lat_flag <= n_lat_flag;
        r_lat_last <= n_lat_last;
        r_rbyte    <= n_rbyte;
        r_rflag    <= n_rflag;
        r_rlast    <= n_rlast;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_read_byte    = r_rbyte;
    assign o_read_is_data = r_rflag;
    assign o_last_of_sdu  = r_rlast;
    // counters only move when a result is produced, so these hold the
    // values after the item during the strobe cycle
    assign o_pdu_bytes    = w_pdu_now[PDU_W-1:0];
    assign o_sdu_total    = TOTAL_W'(r_queued);

    assign prdata = PDATA_W'(r_max);
    assign pready = 1'b1;

    // byte writes and clears raise o_done in the cycle after they are taken
    a_single_cycle_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_BYTE || i_opcode == OP_CLEAR)) |=> o_done)
        else $error("byte or clear item did not complete in one cycle");

    // control sdus are a subset of all queued sdus, table never overfills
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_control <= r_queued) && (r_queued <= QW'(MAX_SDUS)))
        else $error("sdu counters out of range");

    // payload never exceeds the buffer
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LENW'(BUFFER_BYTES))
        else $error("payload length beyond buffer");

    // a table move always ends with the new entry write
    a_shift_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && (r_wr_idx - TW'(1)) == r_pos) |=> (r_state == S_INSERT))
        else $error("table move did not hand over to insert");

endmodule

// ===== hdl/msaq_ram.sv =====
// ----------------------------------------------------------------------------
// msaq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module msaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
